@@ hw/rtl/hds_pkg.sv @@
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types, widths and constants of the heat diffusion stencil step.
// ----------------------------------------------------------------------------
`default_nettype none

package hds_pkg;

    localparam int MAX_COLS   = 32;
    localparam int COL_AW     = $clog2(MAX_COLS);

    localparam int CELL_W     = 32;
    localparam int COEF_W     = 16;
    localparam int ROWS_W     = 16;
    localparam int COLS_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Q16.16 cell, Q0.16 coefficient
    localparam int FRAC_W     = 16;
    localparam int LAP_W      = CELL_W + 2;
    localparam int PROD_W     = LAP_W + COEF_W + 1;
    localparam int ACC_W      = PROD_W + 1;
    localparam int SUM_W      = ACC_W - FRAC_W;
    localparam int RES_W      = SUM_W + 1;

    localparam logic [COEF_W-1:0] COEF_X_RESET   = COEF_W'(6554);
    localparam logic [COEF_W-1:0] COEF_Y_RESET   = COEF_W'(6554);
    localparam logic [ROWS_W-1:0] NUM_ROWS_RESET = ROWS_W'(20);
    localparam logic [COLS_W-1:0] NUM_COLS_RESET = COLS_W'(20);
    localparam logic [ROWS_W-1:0] MIN_ROWS       = ROWS_W'(3);
    localparam logic [COLS_W-1:0] MIN_COLS       = COLS_W'(3);

    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_X   = 2'd0,
        REG_COEF_Y   = 2'd1,
        REG_NUM_ROWS = 2'd2,
        REG_NUM_COLS = 2'd3
    } cfg_reg_t;

    typedef logic [COL_AW-1:0]        col_addr_t;
    typedef logic signed [CELL_W-1:0] cell_t;

    // Clamp a wide signed result to the Q16.16 range.
    function automatic cell_t saturate(input logic signed [RES_W-1:0] v);
        logic [RES_W-CELL_W:0] top;
        cell_t                 r;
        top = v[RES_W-1:CELL_W-1];
        if ((&top) || !(|top))
        begin
            r = v[CELL_W-1:0];
        end
        else if (v[RES_W-1])
        begin
            r = {1'b1, {(CELL_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CELL_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/heat_diffusion_stencil_step_top.sv @@
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step_top
// One explicit five-point-stencil time step over a row-major streamed grid.
// ----------------------------------------------------------------------------
// Takes one cell per cycle and returns one result per cycle unless a low
// out_ready or a grid flush holds the flow; a request passes the read,
// Laplacian, multiply and sum stages before the output register. Results
// trail the input by one grid row. The two line buffers are synchronous RAMs
// of MAX_COLS entries, each read at two addresses per cycle and written once,
// with the write of the request ahead forwarded to the one behind. After the
// final cell of a grid the block holds off input while the last row's
// num_cols cells (clamped to 3..MAX_COLS) are read out of the middle buffer.
`default_nettype none

module heat_diffusion_stencil_step_top
    import hds_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [CELL_W-1:0]     cell_in,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [CELL_W-1:0]          cell_out,
    output logic                       grid_last
);

    // configuration
    logic [COEF_W-1:0] coef_x_reg;
    logic [COEF_W-1:0] coef_y_reg;
    logic [ROWS_W-1:0] num_rows_reg;
    logic [COLS_W-1:0] num_cols_reg;

    // counters and flush sequencer
    logic [ROWS_W-1:0] row_count_reg, row_count_next;
    logic [COLS_W-1:0] col_count_reg, col_count_next;
    logic              flush_active_reg, flush_active_next;
    col_addr_t         flush_idx_reg, flush_idx_next;
    col_addr_t         flush_last_reg, flush_last_next;

    // line buffers
    cell_t upper_row_buf  [MAX_COLS];
    cell_t middle_row_buf [MAX_COLS];

    // read stage
    logic      s1_valid_reg;
    logic      s1_wr_reg, s1_emit_reg, s1_border_reg, s1_last_reg;
    col_addr_t s1_addr_reg;
    cell_t     s1_x_reg;
    cell_t     rd_mc_reg, rd_me_reg, rd_uc_reg, rd_uw_reg;
    logic      fwd_mc_reg, fwd_me_reg, fwd_uc_reg, fwd_uw_reg;
    cell_t     fwd_mid_reg, fwd_up_reg;

    // Laplacian stage
    logic                    s2_valid_reg;
    logic                    s2_border_reg, s2_last_reg;
    cell_t                   s2_u_reg;
    logic signed [LAP_W-1:0] s2_lap_ns_reg, s2_lap_ew_reg;

    // multiply stage
    logic                     s3_valid_reg;
    logic                     s3_border_reg, s3_last_reg;
    cell_t                    s3_u_reg;
    logic signed [PROD_W-1:0] s3_prod_x_reg, s3_prod_y_reg;

    // sum stage
    logic                    s4_valid_reg;
    logic                    s4_border_reg, s4_last_reg;
    cell_t                   s4_u_reg;
    logic signed [SUM_W-1:0] s4_sum_reg;

    // output register
    logic  out_valid_reg;
    cell_t cell_out_reg;
    logic  grid_last_reg;

    // ------------------------------------------------------------------
    // Derived geometry
    // ------------------------------------------------------------------
    logic [COLS_W-1:0] cols_eff;
    logic [COLS_W-1:0] cols_last;
    logic [ROWS_W-1:0] rows_eff;
    logic [ROWS_W-1:0] rows_last;
    col_addr_t         col_eff;

    always_comb
    begin
        if (num_cols_reg < MIN_COLS)
        begin
            cols_eff = MIN_COLS;
        end
        else if (num_cols_reg > COLS_W'(MAX_COLS))
        begin
            cols_eff = COLS_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = num_cols_reg;
        end
        cols_last = cols_eff - COLS_W'(1);
        rows_eff  = (num_rows_reg < MIN_ROWS) ? MIN_ROWS : num_rows_reg;
        rows_last = rows_eff - ROWS_W'(1);
        col_eff   = (col_count_reg > COLS_W'(MAX_COLS - 1)) ?
                    COL_AW'(MAX_COLS - 1) : col_count_reg[COL_AW-1:0];
    end

    // ------------------------------------------------------------------
    // Pipeline enables
    // ------------------------------------------------------------------
    logic en_out, en_s4, en_s3, en_s2, en_s1, s1_go;
    logic a_valid, a_fire, in_fire;

    assign en_out  = !out_valid_reg || out_ready;
    assign en_s4   = !s4_valid_reg || en_out;
    assign en_s3   = !s3_valid_reg || en_s4;
    assign en_s2   = !s2_valid_reg || en_s3;
    // a request that yields no result only needs its buffer write
    assign s1_go   = s1_valid_reg && (!s1_emit_reg || en_s2);
    assign en_s1   = !s1_valid_reg || s1_go;

    assign a_valid  = flush_active_reg || in_valid;
    assign a_fire   = en_s1 && a_valid;
    assign in_ready = en_s1 && !flush_active_reg;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Request entering the read stage: input cell or flush read
    // ------------------------------------------------------------------
    col_addr_t a_addr, a_addr_e, a_addr_w;
    logic      a_wr, a_emit, a_border, a_last;
    logic      end_row, end_grid;

    always_comb
    begin
        end_row  = {1'b0, col_eff} >= cols_last;
        end_grid = row_count_reg >= rows_last;
        if (flush_active_reg)
        begin
            a_addr   = flush_idx_reg;
            a_wr     = 1'b0;
            a_emit   = 1'b1;
            a_border = 1'b1;
            a_last   = (flush_idx_reg == flush_last_reg);
        end
        else
        begin
            a_addr   = col_eff;
            a_wr     = 1'b1;
            a_emit   = (row_count_reg != '0);
            a_border = (row_count_reg == ROWS_W'(1)) || (row_count_reg >= rows_eff) ||
                       (col_eff == '0) || end_row;
            a_last   = 1'b0;
        end
        a_addr_e = a_addr + COL_AW'(1);
        a_addr_w = a_addr - COL_AW'(1);
    end

    // ------------------------------------------------------------------
    // Counters and flush sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        row_count_next    = row_count_reg;
        col_count_next    = col_count_reg;
        flush_active_next = flush_active_reg;
        flush_idx_next    = flush_idx_reg;
        flush_last_next   = flush_last_reg;
        if (in_fire)
        begin
            if (end_row)
            begin
                col_count_next = '0;
                if (end_grid)
                begin
                    row_count_next    = '0;
                    flush_active_next = 1'b1;
                    flush_idx_next    = '0;
                    flush_last_next   = cols_last[COL_AW-1:0];
                end
                else
                begin
                    row_count_next = row_count_reg + ROWS_W'(1);
                end
            end
            else
            begin
                col_count_next = {1'b0, col_eff} + COLS_W'(1);
            end
        end
        else if (a_fire)
        begin
            // advance the flush read
            if (flush_idx_reg == flush_last_reg)
            begin
                flush_active_next = 1'b0;
            end
            else
            begin
                flush_idx_next = flush_idx_reg + COL_AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg       <= COEF_X_RESET;
            coef_y_reg       <= COEF_Y_RESET;
            num_rows_reg     <= NUM_ROWS_RESET;
            num_cols_reg     <= NUM_COLS_RESET;
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            flush_active_reg <= 1'b0;
            flush_idx_reg    <= '0;
            flush_last_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_COEF_X:   coef_x_reg   <= cfg_data[COEF_W-1:0];
                    REG_COEF_Y:   coef_y_reg   <= cfg_data[COEF_W-1:0];
                    REG_NUM_ROWS: num_rows_reg <= cfg_data[ROWS_W-1:0];
                    REG_NUM_COLS: num_cols_reg <= cfg_data[COLS_W-1:0];
                    default:      ;
                endcase
            end
            row_count_reg    <= row_count_next;
            col_count_reg    <= col_count_next;
            flush_active_reg <= flush_active_next;
            flush_idx_reg    <= flush_idx_next;
            flush_last_reg   <= flush_last_next;
        end
    end

    // ------------------------------------------------------------------
    // Read stage: resolve forwarded data, write back the line buffers
    // ------------------------------------------------------------------
    cell_t mc, me, uc, uw;
    logic  wr_now;

    assign mc     = fwd_mc_reg ? fwd_mid_reg : rd_mc_reg;
    assign me     = fwd_me_reg ? fwd_mid_reg : rd_me_reg;
    assign uc     = fwd_uc_reg ? fwd_up_reg  : rd_uc_reg;
    assign uw     = fwd_uw_reg ? fwd_up_reg  : rd_uw_reg;
    assign wr_now = s1_go && s1_wr_reg;

    // Line buffer RAMs: one write, two registered reads each
    always_ff @(posedge clk)
    begin
        if (wr_now)
        begin
            upper_row_buf[s1_addr_reg]  <= mc;
            middle_row_buf[s1_addr_reg] <= s1_x_reg;
        end
        if (a_fire)
        begin
            rd_mc_reg <= middle_row_buf[a_addr];
            rd_me_reg <= middle_row_buf[a_addr_e];
            rd_uc_reg <= upper_row_buf[a_addr];
            rd_uw_reg <= upper_row_buf[a_addr_w];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            s1_wr_reg     <= a_wr;
            s1_emit_reg   <= a_emit;
            s1_border_reg <= a_border;
            s1_last_reg   <= a_last;
            s1_addr_reg   <= a_addr;
            s1_x_reg      <= cell_in;
            // catch the write that lands on the same edge as the read
            fwd_mc_reg    <= wr_now && (s1_addr_reg == a_addr);
            fwd_me_reg    <= wr_now && (s1_addr_reg == a_addr_e);
            fwd_uc_reg    <= wr_now && (s1_addr_reg == a_addr);
            fwd_uw_reg    <= wr_now && (s1_addr_reg == a_addr_w);
            fwd_mid_reg   <= s1_x_reg;
            fwd_up_reg    <= mc;
        end
    end

    // ------------------------------------------------------------------
    // Datapath stages
    // ------------------------------------------------------------------
    logic signed [LAP_W-1:0] lap_ns, lap_ew, two_u;
    logic signed [ACC_W-1:0] acc;
    logic signed [RES_W-1:0] res;

    always_comb
    begin
        two_u  = {{(LAP_W-CELL_W){mc[CELL_W-1]}}, mc} <<< 1;
        lap_ns = {{(LAP_W-CELL_W){uc[CELL_W-1]}}, uc} +
                 {{(LAP_W-CELL_W){s1_x_reg[CELL_W-1]}}, s1_x_reg} - two_u;
        lap_ew = {{(LAP_W-CELL_W){me[CELL_W-1]}}, me} +
                 {{(LAP_W-CELL_W){uw[CELL_W-1]}}, uw} - two_u;
        acc    = {s3_prod_x_reg[PROD_W-1], s3_prod_x_reg} +
                 {s3_prod_y_reg[PROD_W-1], s3_prod_y_reg} + ROUND_BIAS;
        res    = {{(RES_W-CELL_W){s4_u_reg[CELL_W-1]}}, s4_u_reg} +
                 {s4_sum_reg[SUM_W-1], s4_sum_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en_s2)
        begin
            s2_border_reg <= s1_border_reg;
            s2_last_reg   <= s1_last_reg;
            s2_u_reg      <= mc;
            s2_lap_ns_reg <= lap_ns;
            s2_lap_ew_reg <= lap_ew;
        end
        if (en_s3)
        begin
            s3_border_reg <= s2_border_reg;
            s3_last_reg   <= s2_last_reg;
            s3_u_reg      <= s2_u_reg;
            s3_prod_x_reg <= s2_lap_ns_reg * $signed({1'b0, coef_x_reg});
            s3_prod_y_reg <= s2_lap_ew_reg * $signed({1'b0, coef_y_reg});
        end
        if (en_s4)
        begin
            s4_border_reg <= s3_border_reg;
            s4_last_reg   <= s3_last_reg;
            s4_u_reg      <= s3_u_reg;
            // floor shift after the half-LSB bias rounds half up
            s4_sum_reg    <= $signed(acc[ACC_W-1:FRAC_W]);
        end
        if (en_out)
        begin
            cell_out_reg  <= s4_border_reg ? s4_u_reg : saturate(res);
            grid_last_reg <= s4_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
            begin
                s1_valid_reg <= a_valid;
            end
            if (en_s2)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (en_s3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en_s4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign grid_last = grid_last_reg;

endmodule

`default_nettype wire
